@@ hdl/cite_pkg.sv @@
// ----------------------------------------------------------------------------
// cite_pkg
// shared types, constants and corner/edge tables for the tetra extractor
// ----------------------------------------------------------------------------
`default_nettype none

package cite_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int GRID_SIZE   = 256;
   localparam int VAL_W       = 24;
   localparam int COORD_W     = 25;
   localparam int POS_W       = 9;
   localparam int CALC_W      = POS_W + FRAC_BITS;
   localparam int DIFF_W      = FRAC_BITS + 2;
   localparam int PROD_W      = 2 * DIFF_W;
   localparam int NRM_W       = PROD_W + 1;
   localparam int DOT_W       = PROD_W + 3;
   localparam int SEG_W       = DIFF_W + 2;
   localparam int Q_W         = FRAC_BITS + 1;
   localparam int NUM_W       = VAL_W + FRAC_BITS;
   localparam int LANE_LAT    = Q_W + 1;
   localparam int NUM_LANES   = 20;
   localparam int LANE_W      = 5;
   localparam int NUM_SLOTS   = 12;
   localparam int SLOT_W      = 4;
   localparam int NUM_CORNERS = 8;

   localparam int LO_INT = ((1 << FRAC_BITS) + 500) / 1000;
   localparam logic [Q_W-1:0] MARGIN_LO = Q_W'(LO_INT);
   localparam logic [Q_W-1:0] MARGIN_HI = Q_W'((1 << FRAC_BITS) - LO_INT);
   localparam logic [VAL_W-1:0] UNDEF_VAL = {1'b1, {(VAL_W-1){1'b0}}};

   typedef logic [2:0] corner_type;
   typedef corner_type [3:0] quad_type;
   typedef logic [2:0][CALC_W-1:0] pt_type;

   typedef struct packed {
      logic [7:0]              cube_x;
      logic [7:0]              cube_y;
      logic [7:0]              cube_z;
      logic signed [VAL_W-1:0] corner_000;
      logic signed [VAL_W-1:0] corner_001;
      logic signed [VAL_W-1:0] corner_010;
      logic signed [VAL_W-1:0] corner_011;
      logic signed [VAL_W-1:0] corner_100;
      logic signed [VAL_W-1:0] corner_101;
      logic signed [VAL_W-1:0] corner_110;
      logic signed [VAL_W-1:0] corner_111;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] first_x;
      logic [COORD_W-1:0] first_y;
      logic [COORD_W-1:0] first_z;
      logic [COORD_W-1:0] second_x;
      logic [COORD_W-1:0] second_y;
      logic [COORD_W-1:0] second_z;
      logic [COORD_W-1:0] third_x;
      logic [COORD_W-1:0] third_y;
      logic [COORD_W-1:0] third_z;
      logic               is_segment;
      logic [1:0]         clamped_points;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [1:0][POS_W-1:0] px;
      logic [1:0][POS_W-1:0] py;
      logic [1:0][POS_W-1:0] pz;
   } pos_type;

   typedef struct packed {
      logic                 planar;
      logic [7:0]           pos_sign;
      logic [NUM_SLOTS-1:0] mask;
      pos_type              pos;
   } cube_type;

   typedef struct packed {
      corner_type [2:0] p;
      corner_type [2:0] n;
   } edges_type;

   localparam corner_type KUHN [6][4] = '{
      '{3'd0, 3'd1, 3'd5, 3'd2}, '{3'd0, 3'd5, 3'd4, 3'd2},
      '{3'd5, 3'd6, 3'd4, 3'd2}, '{3'd2, 3'd3, 3'd1, 3'd5},
      '{3'd7, 3'd3, 3'd2, 3'd5}, '{3'd7, 3'd2, 3'd6, 3'd5}};

   localparam corner_type FACE [2][3] = '{'{3'd0, 3'd3, 3'd1}, '{3'd0, 3'd2, 3'd3}};

   // endpoints of each divider lane: twelve cube edges, seven diagonals, face diagonal
   localparam corner_type LANE_A [NUM_LANES] = '{
      3'd0, 3'd2, 3'd4, 3'd6, 3'd0, 3'd1, 3'd4, 3'd5, 3'd0, 3'd1,
      3'd2, 3'd3, 3'd0, 3'd1, 3'd2, 3'd5, 3'd3, 3'd2, 3'd2, 3'd0};
   localparam corner_type LANE_B [NUM_LANES] = '{
      3'd1, 3'd3, 3'd5, 3'd7, 3'd2, 3'd3, 3'd6, 3'd7, 3'd4, 3'd5,
      3'd6, 3'd7, 3'd5, 3'd2, 3'd4, 3'd6, 3'd5, 3'd7, 3'd5, 3'd3};

   function automatic logic [LANE_W-1:0] lane_of(corner_type a, corner_type b);
      corner_type lo;
      corner_type hi;
      logic [LANE_W-1:0] r;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      unique case ({lo, hi})
         {3'd0, 3'd1}: r = LANE_W'(0);
         {3'd2, 3'd3}: r = LANE_W'(1);
         {3'd4, 3'd5}: r = LANE_W'(2);
         {3'd6, 3'd7}: r = LANE_W'(3);
         {3'd0, 3'd2}: r = LANE_W'(4);
         {3'd1, 3'd3}: r = LANE_W'(5);
         {3'd4, 3'd6}: r = LANE_W'(6);
         {3'd5, 3'd7}: r = LANE_W'(7);
         {3'd0, 3'd4}: r = LANE_W'(8);
         {3'd1, 3'd5}: r = LANE_W'(9);
         {3'd2, 3'd6}: r = LANE_W'(10);
         {3'd3, 3'd7}: r = LANE_W'(11);
         {3'd0, 3'd5}: r = LANE_W'(12);
         {3'd1, 3'd2}: r = LANE_W'(13);
         {3'd2, 3'd4}: r = LANE_W'(14);
         {3'd5, 3'd6}: r = LANE_W'(15);
         {3'd3, 3'd5}: r = LANE_W'(16);
         {3'd2, 3'd7}: r = LANE_W'(17);
         {3'd2, 3'd5}: r = LANE_W'(18);
         {3'd0, 3'd3}: r = LANE_W'(19);
         default:      r = '0;
      endcase
      return r;
   endfunction

   // positive corners to the front, two pointers closing from both ends
   function automatic quad_type sort_pos(quad_type v_in, logic [7:0] sg, logic [2:0] cnt);
      quad_type v;
      logic [2:0] i;
      logic [2:0] j;
      corner_type tmp;
      v = v_in;
      i = 3'd0;
      j = cnt - 3'd1;
      for (int k = 0; k < 4; k++) begin
         if (i < j) begin
            if (sg[v[i[1:0]]]) begin
               i = i + 3'd1;
            end else if (!sg[v[j[1:0]]]) begin
               j = j - 3'd1;
            end else begin
               tmp = v[i[1:0]];
               v[i[1:0]] = v[j[1:0]];
               v[j[1:0]] = tmp;
               i = i + 3'd1;
               j = j - 3'd1;
            end
         end
      end
      return v;
   endfunction

   function automatic logic [2:0] count_pos(quad_type v, logic [7:0] sg, logic [2:0] cnt);
      logic [2:0] np;
      np = 3'd0;
      for (int k = 0; k < 4; k++) begin
         if (3'(k) < cnt) np = np + 3'(sg[v[k]]);
      end
      return np;
   endfunction

   function automatic quad_type tet_quad(logic [2:0] tet_in);
      quad_type v;
      logic [2:0] tet;
      tet = (tet_in > 3'd5) ? 3'd0 : tet_in;
      for (int k = 0; k < 4; k++) v[k] = KUHN[tet][k];
      return v;
   endfunction

   function automatic quad_type face_quad(logic f);
      quad_type v;
      for (int k = 0; k < 3; k++) v[k] = FACE[f][k];
      v[3] = FACE[f][0];
      return v;
   endfunction

   function automatic logic [NUM_SLOTS-1:0] mask_of(logic [7:0] sg, logic planar,
                                                     logic undef);
      logic [NUM_SLOTS-1:0] m;
      logic [2:0] np;
      m = '0;
      if (planar) begin
         for (int f = 0; f < 2; f++) begin
            np = count_pos(face_quad(f[0]), sg, 3'd3);
            m[f] = (np == 3'd1) || (np == 3'd2);
         end
      end else begin
         for (int t = 0; t < 6; t++) begin
            np = count_pos(tet_quad(3'(t)), sg, 3'd4);
            m[2*t]   = (np != 3'd0) && (np != 3'd4);
            m[2*t+1] = (np == 3'd2);
         end
      end
      if (undef) m = '0;
      return m;
   endfunction

   function automatic edges_type slot_edges(logic [7:0] sg, logic planar,
                                            logic [SLOT_W-1:0] slot);
      quad_type v;
      logic [2:0] np;
      edges_type e;
      if (planar) begin
         v  = sort_pos(face_quad(slot[0]), sg, 3'd3);
         np = count_pos(v, sg, 3'd3);
         if (np == 3'd1) begin
            e.p[0] = v[0]; e.n[0] = v[1];
            e.p[1] = v[0]; e.n[1] = v[2];
         end else begin
            e.p[0] = v[0]; e.n[0] = v[2];
            e.p[1] = v[1]; e.n[1] = v[2];
         end
         e.p[2] = e.p[0]; e.n[2] = e.n[0];
      end else begin
         v  = sort_pos(tet_quad(slot[3:1]), sg, 3'd4);
         np = count_pos(v, sg, 3'd4);
         if (np == 3'd1) begin
            e.p[0] = v[0]; e.n[0] = v[1];
            e.p[1] = v[0]; e.n[1] = v[2];
            e.p[2] = v[0]; e.n[2] = v[3];
         end else if (np == 3'd2 && !slot[0]) begin
            e.p[0] = v[0]; e.n[0] = v[2];
            e.p[1] = v[0]; e.n[1] = v[3];
            e.p[2] = v[1]; e.n[2] = v[3];
         end else if (np == 3'd2) begin
            e.p[0] = v[0]; e.n[0] = v[2];
            e.p[1] = v[1]; e.n[1] = v[3];
            e.p[2] = v[1]; e.n[2] = v[2];
         end else begin
            e.p[0] = v[0]; e.n[0] = v[3];
            e.p[1] = v[1]; e.n[1] = v[3];
            e.p[2] = v[2]; e.n[2] = v[3];
         end
      end
      return e;
   endfunction

   function automatic logic [POS_W-1:0] pos_clip(logic [7:0] b, logic off);
      logic [9:0] g;
      g = 10'(b) + 10'(off);
      if (g > 10'(GRID_SIZE)) g = 10'(GRID_SIZE);
      return g[POS_W-1:0];
   endfunction

   function automatic logic [CALC_W-1:0] axis_point(logic [1:0][POS_W-1:0] ax, logic bp,
                                                   logic bn, logic [FRAC_BITS-1:0] t);
      logic [CALC_W-1:0] base;
      logic [CALC_W-1:0] r;
      base = {ax[bp], {FRAC_BITS{1'b0}}};
      if (ax[bn] > ax[bp])      r = base + CALC_W'(t);
      else if (ax[bn] < ax[bp]) r = base - CALC_W'(t);
      else                      r = base;
      return r;
   endfunction

   function automatic pt_type edge_point(pos_type pos, corner_type p, corner_type n,
                                         logic [FRAC_BITS-1:0] t);
      pt_type r;
      r[0] = axis_point(pos.px, p[2], n[2], t);
      r[1] = axis_point(pos.py, p[1], n[1], t);
      r[2] = axis_point(pos.pz, p[0], n[0], t);
      return r;
   endfunction

   function automatic logic [COORD_W-1:0] fit_coord(logic [CALC_W-1:0] v);
      logic [CALC_W+COORD_W-1:0] w;
      w = {{COORD_W{1'b0}}, v};
      return w[COORD_W-1:0];
   endfunction

endpackage

`default_nettype wire

@@ hdl/cite_div_lane.sv @@
// ----------------------------------------------------------------------------
// cite_div_lane
// one edge lane: pipelined restoring divider for the edge fraction, then clamp
// ----------------------------------------------------------------------------
`default_nettype none

module cite_div_lane
   import cite_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    en,
   input  wire logic signed [VAL_W-1:0] val_a,
   input  wire logic signed [VAL_W-1:0] val_b,
   output logic [FRAC_BITS-1:0]         t,
   output logic                         clamped
);

   logic [VAL_W-1:0] vp;
   logic [VAL_W-1:0] vn;
   logic [VAL_W:0]   den_full;
   logic [NUM_W-1:0] num_in;

   logic [NUM_W-1:0] num_ff;
   logic [VAL_W-1:0] den_ff;

   logic [VAL_W-1:0] rem_ff [Q_W];
   logic [VAL_W-1:0] dsr_ff [Q_W];
   logic [Q_W-1:0]   nlo_ff [Q_W];
   logic [Q_W-1:0]   quo_ff [Q_W];

   // positive end first
   always_comb begin
      vp       = val_a[VAL_W-1] ? val_b : val_a;
      vn       = val_a[VAL_W-1] ? val_a : val_b;
      den_full = {vp[VAL_W-1], vp} - {vn[VAL_W-1], vn};
      num_in   = (NUM_W'(vp[VAL_W-2:0]) << FRAC_BITS) + NUM_W'(den_full[VAL_W-1:1]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= num_in;
         den_ff <= den_full[VAL_W-1:0];
      end
   end

   for (genvar s = 0; s < Q_W; s++) begin : g_stage
      logic [VAL_W-1:0] rin;
      logic [VAL_W-1:0] din;
      logic [Q_W-1:0]   lin;
      logic [Q_W-1:0]   qin;
      logic [VAL_W:0]   shifted;
      logic             ge;
      logic [VAL_W:0]   sub;
      logic [VAL_W-1:0] rem_in;

      if (s == 0) begin : g_first
         assign rin = {1'b0, num_ff[NUM_W-1:Q_W]};
         assign din = den_ff;
         assign lin = num_ff[Q_W-1:0];
         assign qin = '0;
      end else begin : g_next
         assign rin = rem_ff[s-1];
         assign din = dsr_ff[s-1];
         assign lin = nlo_ff[s-1];
         assign qin = quo_ff[s-1];
      end

      always_comb begin
         shifted = {rin, lin[Q_W-1-s]};
         ge      = shifted >= {1'b0, din};
         sub     = shifted - {1'b0, din};
         rem_in  = ge ? sub[VAL_W-1:0] : shifted[VAL_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_in;
            dsr_ff[s] <= din;
            nlo_ff[s] <= lin;
            quo_ff[s] <= {qin[Q_W-2:0], ge};
         end
      end
   end

   // keep the point off the corners
   always_comb begin
      if (quo_ff[Q_W-1] < MARGIN_LO) begin
         t       = MARGIN_LO[FRAC_BITS-1:0];
         clamped = 1'b1;
      end else if (quo_ff[Q_W-1] > MARGIN_HI) begin
         t       = MARGIN_HI[FRAC_BITS-1:0];
         clamped = 1'b1;
      end else begin
         t       = quo_ff[Q_W-1][FRAC_BITS-1:0];
         clamped = 1'b0;
      end
   end

endmodule

`default_nettype wire

@@ hdl/cite_emit.sv @@
// ----------------------------------------------------------------------------
// cite_emit
// merges lane results: walks the active primitives of a cube, when not stalled one per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module cite_emit
   import cite_pkg::*;
(
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 in_valid,
   input  wire cube_type                             cube,
   input  wire logic [NUM_LANES-1:0][FRAC_BITS-1:0]  lane_t,
   input  wire logic [NUM_LANES-1:0]                 lane_cl,
   output logic                                      take,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output rsp_type                                   rsp_data
);

   // cube being walked
   logic [NUM_SLOTS-1:0]                mask_ff;
   logic [NUM_SLOTS-1:0]                mask_in;
   logic                                planar_ff;
   logic [7:0]                          sign_ff;
   pos_type                             pos_ff;
   logic [NUM_LANES-1:0][FRAC_BITS-1:0] t_ff;
   logic [NUM_LANES-1:0]                cl_ff;

   logic                  en;
   logic                  busy;
   logic [SLOT_W-1:0]     slot;
   logic [NUM_SLOTS-1:0]  mask_next;
   edges_type             edg;
   logic [LANE_W-1:0]     ln0, ln1, ln2;
   pt_type                pa0, pa1, pa2;
   logic [1:0]            cl_sum;
   logic [2:0]            dpos, dneg;

   // point stage
   logic        a_valid_ff;
   pt_type      a_q0_ff, a_q1_ff, a_q2_ff;
   logic [2:0]  a_dpos_ff, a_dneg_ff;
   logic        a_seg_ff, a_last_ff;
   logic [1:0]  a_cl_ff;

   // product stage
   logic                     b_valid_ff;
   pt_type                   b_q0_ff, b_q1_ff, b_q2_ff;
   logic [2:0]               b_dpos_ff, b_dneg_ff;
   logic                     b_seg_ff, b_last_ff;
   logic [1:0]               b_cl_ff;
   logic signed [DIFF_W-1:0] b_u_ff [3];
   logic signed [PROD_W-1:0] b_m_ff [6];

   logic signed [DIFF_W-1:0] u_in [3];
   logic signed [DIFF_W-1:0] w_in [3];
   logic [CALC_W:0]          du, dw;

   logic signed [NRM_W-1:0]  nrm [3];
   logic signed [DOT_W-1:0]  dot;
   logic signed [SEG_W-1:0]  sdot;
   logic                     swap;
   pt_type                   o0, o1;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign busy      = |mask_ff;
   assign mask_next = mask_ff & (mask_ff - NUM_SLOTS'(1));
   assign take      = en && (mask_next == '0);

   always_comb begin
      slot = '0;
      for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
         if (mask_ff[k]) slot = SLOT_W'(k);
      end
   end

   assign mask_in = (take && in_valid) ? cube.mask : mask_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else if (en) begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && in_valid) begin
         planar_ff <= cube.planar;
         sign_ff   <= cube.pos_sign;
         pos_ff    <= cube.pos;
         t_ff      <= lane_t;
         cl_ff     <= lane_cl;
      end
   end

   // points of the selected primitive
   always_comb begin
      edg    = slot_edges(sign_ff, planar_ff, slot);
      ln0    = lane_of(edg.p[0], edg.n[0]);
      ln1    = lane_of(edg.p[1], edg.n[1]);
      ln2    = lane_of(edg.p[2], edg.n[2]);
      pa0    = edge_point(pos_ff, edg.p[0], edg.n[0], t_ff[ln0]);
      pa1    = edge_point(pos_ff, edg.p[1], edg.n[1], t_ff[ln1]);
      pa2    = edge_point(pos_ff, edg.p[2], edg.n[2], t_ff[ln2]);
      cl_sum = 2'(cl_ff[ln0]) + 2'(cl_ff[ln1]) + (planar_ff ? 2'd0 : 2'(cl_ff[ln2]));
      dpos[0] = pos_ff.px[edg.p[0][2]] > pos_ff.px[edg.n[0][2]];
      dneg[0] = pos_ff.px[edg.p[0][2]] < pos_ff.px[edg.n[0][2]];
      dpos[1] = pos_ff.py[edg.p[0][1]] > pos_ff.py[edg.n[0][1]];
      dneg[1] = pos_ff.py[edg.p[0][1]] < pos_ff.py[edg.n[0][1]];
      dpos[2] = pos_ff.pz[edg.p[0][0]] > pos_ff.pz[edg.n[0][0]];
      dneg[2] = pos_ff.pz[edg.p[0][0]] < pos_ff.pz[edg.n[0][0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= busy;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_q0_ff   <= pa0;
         a_q1_ff   <= pa1;
         a_q2_ff   <= pa2;
         a_dpos_ff <= dpos;
         a_dneg_ff <= dneg;
         a_seg_ff  <= planar_ff;
         a_last_ff <= (mask_next == '0);
         a_cl_ff   <= cl_sum;
      end
   end

   // edge vectors and cross-product terms
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         du      = {1'b0, a_q1_ff[a]} - {1'b0, a_q0_ff[a]};
         dw      = {1'b0, a_q2_ff[a]} - {1'b0, a_q0_ff[a]};
         u_in[a] = $signed(du[DIFF_W-1:0]);
         w_in[a] = $signed(dw[DIFF_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_q0_ff   <= a_q0_ff;
         b_q1_ff   <= a_q1_ff;
         b_q2_ff   <= a_q2_ff;
         b_dpos_ff <= a_dpos_ff;
         b_dneg_ff <= a_dneg_ff;
         b_seg_ff  <= a_seg_ff;
         b_last_ff <= a_last_ff;
         b_cl_ff   <= a_cl_ff;
         for (int a = 0; a < 3; a++) b_u_ff[a] <= u_in[a];
         b_m_ff[0] <= u_in[1] * w_in[2];
         b_m_ff[1] <= u_in[2] * w_in[1];
         b_m_ff[2] <= u_in[2] * w_in[0];
         b_m_ff[3] <= u_in[0] * w_in[2];
         b_m_ff[4] <= u_in[0] * w_in[1];
         b_m_ff[5] <= u_in[1] * w_in[0];
      end
   end

   // orientation and result assembly
   always_comb begin
      nrm[0] = NRM_W'(b_m_ff[0]) - NRM_W'(b_m_ff[1]);
      nrm[1] = NRM_W'(b_m_ff[2]) - NRM_W'(b_m_ff[3]);
      nrm[2] = NRM_W'(b_m_ff[4]) - NRM_W'(b_m_ff[5]);
      dot = '0;
      for (int a = 0; a < 3; a++) begin
         if (b_dpos_ff[a])      dot = dot + DOT_W'(nrm[a]);
         else if (b_dneg_ff[a]) dot = dot - DOT_W'(nrm[a]);
      end
      sdot = '0;
      if (b_dpos_ff[1])      sdot = sdot - SEG_W'(b_u_ff[2]);
      else if (b_dneg_ff[1]) sdot = sdot + SEG_W'(b_u_ff[2]);
      if (b_dpos_ff[2])      sdot = sdot + SEG_W'(b_u_ff[1]);
      else if (b_dneg_ff[2]) sdot = sdot - SEG_W'(b_u_ff[1]);
      swap = b_seg_ff ? sdot[SEG_W-1] : dot[DOT_W-1];
      o0   = swap ? b_q1_ff : b_q0_ff;
      o1   = swap ? b_q0_ff : b_q1_ff;

      rsp_data_in.first_x        = fit_coord(o0[0]);
      rsp_data_in.first_y        = fit_coord(o0[1]);
      rsp_data_in.first_z        = fit_coord(o0[2]);
      rsp_data_in.second_x       = fit_coord(o1[0]);
      rsp_data_in.second_y       = fit_coord(o1[1]);
      rsp_data_in.second_z       = fit_coord(o1[2]);
      rsp_data_in.third_x        = b_seg_ff ? '0 : fit_coord(b_q2_ff[0]);
      rsp_data_in.third_y        = b_seg_ff ? '0 : fit_coord(b_q2_ff[1]);
      rsp_data_in.third_z        = b_seg_ff ? '0 : fit_coord(b_q2_ff[2]);
      rsp_data_in.is_segment     = b_seg_ff;
      rsp_data_in.clamped_points = b_cl_ff;
      rsp_data_in.last           = b_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

@@ hdl/cube_isosurface_tetra_extract_top.sv @@
// ----------------------------------------------------------------------------
// cube_isosurface_tetra_extract_top: input register, divider lanes, then the merge stage
// a cube holds the walker for all its primitives, one result per cycle unless stalled
// front pipeline (input register, 18-stage divider lanes) moves in lockstep
// synchronous active-high reset clears valids, walker and planar_mode (to 0)
// ----------------------------------------------------------------------------
`default_nettype none

module cube_isosurface_tetra_extract_top
   import cite_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   // input items: one cube each
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   // result items: one primitive each
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data,
   // planar_mode register
   input  wire logic    csr_we,
   input  wire logic    csr_wdata
);

   // mode register
   logic planar_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         planar_ff <= 1'b0;
      end else if (csr_we) begin
         planar_ff <= csr_wdata;
      end
   end

   // whole front pipe advances together
   logic adv;
   logic take;

   // input register
   logic    v0_ff;
   req_type req_ff;
   logic    planar0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         req_ff     <= req_data;
         planar0_ff <= planar_ff;
      end
   end

   // corner values indexed by x*4 + y*2 + z
   logic signed [VAL_W-1:0] corner_val [NUM_CORNERS];
   logic                    undef;
   cube_type                cube_d;

   always_comb begin
      corner_val[0] = req_ff.corner_000;
      corner_val[1] = req_ff.corner_001;
      corner_val[2] = req_ff.corner_010;
      corner_val[3] = req_ff.corner_011;
      corner_val[4] = req_ff.corner_100;
      corner_val[5] = req_ff.corner_101;
      corner_val[6] = req_ff.corner_110;
      corner_val[7] = req_ff.corner_111;

      // planar mode only looks at the lower-x face
      undef = 1'b0;
      for (int i = 0; i < NUM_CORNERS; i++) begin
         if ((i < 4 || !planar0_ff) && corner_val[i] == UNDEF_VAL) undef = 1'b1;
      end

      cube_d.planar = planar0_ff;
      for (int i = 0; i < NUM_CORNERS; i++) begin
         cube_d.pos_sign[i] = !corner_val[i][VAL_W-1];   // zero counts as positive
      end
      cube_d.mask = mask_of(cube_d.pos_sign, planar0_ff, undef);
      for (int k = 0; k < 2; k++) begin
         cube_d.pos.px[k] = pos_clip(req_ff.cube_x, k[0]);
         cube_d.pos.py[k] = pos_clip(req_ff.cube_y, k[0]);
         cube_d.pos.pz[k] = pos_clip(req_ff.cube_z, k[0]);
      end
   end

   // cube side data travelling alongside the divider lanes
   logic     scv_ff [LANE_LAT];
   cube_type sc_ff  [LANE_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < LANE_LAT; s++) scv_ff[s] <= 1'b0;
      end else if (adv) begin
         scv_ff[0] <= v0_ff;
         for (int s = 1; s < LANE_LAT; s++) scv_ff[s] <= scv_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sc_ff[0] <= cube_d;
         for (int s = 1; s < LANE_LAT; s++) sc_ff[s] <= sc_ff[s-1];
      end
   end

   // one divider lane per edge or diagonal that any split can cross
   logic [NUM_LANES-1:0][FRAC_BITS-1:0] lane_t;
   logic [NUM_LANES-1:0]                lane_cl;

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      cite_div_lane u_lane (
         .clock   (clock),
         .en      (adv),
         .val_a   (corner_val[LANE_A[g]]),
         .val_b   (corner_val[LANE_B[g]]),
         .t       (lane_t[g]),
         .clamped (lane_cl[g])
      );
   end

   // hold everything while the tail cube waits for the walker
   assign adv       = !scv_ff[LANE_LAT-1] || take;
   assign req_stall = !adv;

   // merge stage: primitive walker, orientation and output register
   cite_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (scv_ff[LANE_LAT-1]),
      .cube      (sc_ff[LANE_LAT-1]),
      .lane_t    (lane_t),
      .lane_cl   (lane_cl),
      .take      (take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
